// ===== design/fds_pkg.sv =====
// Package for the float-to-decimal split core: field widths, decode constants
// and the power-of-ten table. No dependencies.
`timescale 1ns / 1ps

package fds_pkg;

    localparam int unsigned MAX_DIGITS = 9;

    localparam int unsigned BITS_W   = 32;
    localparam int unsigned DIGITS_W = 4;
    localparam int unsigned INT_W    = 31;
    localparam int unsigned FRAC_W   = 30;
    localparam int unsigned MANT_W   = 24;
    localparam int unsigned SHIFT_W  = 6;
    localparam int unsigned PROD_W   = MANT_W + FRAC_W;
    localparam int unsigned SUM_W    = PROD_W + 2;

    localparam logic [7:0] EXP_ALL_ONES  = 8'hFF;
    localparam logic [7:0] EXP_UNIT      = 8'd150;  // exponent where the LSB weighs one
    localparam logic [7:0] EXP_SAT       = 8'd157;  // above this the integer exceeds 31 bits
    localparam logic [7:0] SUBNORM_SHIFT = 8'd149;
    localparam logic [7:0] MAX_SHIFT     = 8'd55;   // beyond this the fraction rounds to zero

    localparam logic [DIGITS_W-1:0] DIGITS_LIMIT = DIGITS_W'(MAX_DIGITS);
    localparam logic [INT_W-1:0]    INT_MAX      = 31'h7FFF_FFFF;

    typedef logic [FRAC_W-1:0] frac_t;

    // Ten to the given digit count; codes above nine never reach this after clamping.
    function automatic frac_t pow10(input logic [DIGITS_W-1:0] digits);
        frac_t result;
        case (digits)
            4'd0:    result = 30'd1;
            4'd1:    result = 30'd10;
            4'd2:    result = 30'd100;
            4'd3:    result = 30'd1000;
            4'd4:    result = 30'd10000;
            4'd5:    result = 30'd100000;
            4'd6:    result = 30'd1000000;
            4'd7:    result = 30'd10000000;
            4'd8:    result = 30'd100000000;
            4'd9:    result = 30'd1000000000;
            default: result = 30'd1000000000;
        endcase
        return result;
    endfunction

endpackage

// ===== design/float_to_decimal_split_core.sv =====
// Float-to-decimal split core: single-precision pattern in, sign / integer /
// decimal fraction out. Depends on fds_pkg.
`timescale 1ns / 1ps

//  channel   | signals                                            | direction
//  ----------+----------------------------------------------------+----------
//  input     | in_valid, in_ready, value_bits                     | in
//  result    | out_valid, out_ready, negative, integer_part,      | out
//            | fraction_part, overflow                            |
//  config    | cfg_write_en, cfg_write_data (frac_digits)         | in
//
//  One beat enters per cycle while in_ready is high; each result passes in order through the stages below.
//  Stages: decode and mantissa split, remainder times ten to the digits,
//  round and shift, digit carry into the integer part (output register).
//  rst_n clears all valid bits and sets frac_digits to two.
//  A stalled output holds only the stages behind it that are full; bubbles close up.
module float_to_decimal_split_core
    import fds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BITS_W-1:0]   value_bits,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                negative,
    output logic [INT_W-1:0]    integer_part,
    output logic [FRAC_W-1:0]   fraction_part,
    output logic                overflow,
    input  logic                cfg_write_en,
    input  logic [DIGITS_W-1:0] cfg_write_data
);

    logic [DIGITS_W-1:0] frac_digits_reg;

    // stage 1: decode
    logic                s1_valid_reg;
    logic                s1_neg_reg, s1_ovf_reg, s1_rnd_reg;
    logic [INT_W-1:0]    s1_q_reg;
    logic [MANT_W-1:0]   s1_rem_reg;
    logic [SHIFT_W-1:0]  s1_sh_reg;
    logic [DIGITS_W-1:0] s1_digits_reg;

    // stage 2: product
    logic                s2_valid_reg;
    logic                s2_neg_reg, s2_ovf_reg, s2_rnd_reg;
    logic [INT_W-1:0]    s2_q_reg;
    logic [SHIFT_W-1:0]  s2_sh_reg;
    logic [DIGITS_W-1:0] s2_digits_reg;
    logic [PROD_W-1:0]   s2_prod_reg;

    // stage 3: rounded fraction
    logic                s3_valid_reg;
    logic                s3_neg_reg, s3_ovf_reg;
    logic [INT_W-1:0]    s3_q_reg;
    logic [DIGITS_W-1:0] s3_digits_reg;
    logic [FRAC_W-1:0]   s3_f_reg;

    // stage 4: output register
    logic                out_valid_reg;
    logic                neg_reg, ovf_reg;
    logic [INT_W-1:0]    int_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic [DIGITS_W-1:0] out_digits_reg;

    logic out_free, s3_free, s2_free, s1_free;

    // Per-stage ready chain: a stage may load when empty or when its successor moves.
    assign out_free = !out_valid_reg || out_ready;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_digits_reg <= 4'd2;
        end
        else if (cfg_write_en)
        begin
            frac_digits_reg <= cfg_write_data;
        end
    end

    // Stage 1 logic: split magnitude into integer q and fractional remainder rem
    logic [7:0]          expo;
    logic [MANT_W-1:0]   mant;
    logic [7:0]          sh_full;
    logic [2:0]          up_shift;
    logic                s1_ovf_next, s1_rnd_next;
    logic [INT_W-1:0]    s1_q_next;
    logic [MANT_W-1:0]   s1_rem_next;
    logic [SHIFT_W-1:0]  s1_sh_next;
    logic [DIGITS_W-1:0] s1_digits_next;

    always_comb
    begin
        expo           = value_bits[30:23];
        mant           = {expo != 8'd0, value_bits[22:0]};
        sh_full        = (expo == 8'd0) ? SUBNORM_SHIFT : EXP_UNIT - expo;
        up_shift       = 3'(expo - EXP_UNIT);
        s1_digits_next = (frac_digits_reg > DIGITS_LIMIT) ? DIGITS_LIMIT : frac_digits_reg;
        s1_ovf_next    = 1'b0;
        s1_rnd_next    = 1'b0;
        s1_q_next      = '0;
        s1_rem_next    = '0;
        s1_sh_next     = '0;
        if (expo == EXP_ALL_ONES || expo > EXP_SAT)
        begin
            s1_ovf_next = 1'b1;
            s1_q_next   = INT_MAX;
        end
        else if (expo >= EXP_UNIT)
        begin
            s1_q_next = INT_W'(mant) << up_shift;
        end
        else if (sh_full <= MAX_SHIFT)
        begin
            s1_sh_next  = sh_full[SHIFT_W-1:0];
            s1_q_next   = INT_W'(mant >> s1_sh_next);
            s1_rem_next = mant & ~({MANT_W{1'b1}} << s1_sh_next);
            s1_rnd_next = (s1_digits_next != '0);
        end
    end

    // Stage 2 logic: scale the remainder by ten to the digits
    logic [PROD_W-1:0] s2_prod_next;
    assign s2_prod_next = PROD_W'(s1_rem_reg) * PROD_W'(pow10(s1_digits_reg));

    // Stage 3 logic: add half an output LSB and drop the binary fraction
    logic [SUM_W-1:0]   half, sum, f_wide;
    logic [SHIFT_W-1:0] sh_less;
    assign sh_less = s2_sh_reg - SHIFT_W'(1);
    assign half    = s2_rnd_reg ? (SUM_W'(1) << sh_less) : '0;
    assign sum     = SUM_W'(s2_prod_reg) + half;
    assign f_wide  = sum >> s2_sh_reg;

    // Stage 4 logic: a fraction that rounded up to a whole carries into the integer
    logic              carry;
    logic [INT_W-1:0]  int_next;
    logic [FRAC_W-1:0] frac_next;
    assign carry     = (s3_f_reg == pow10(s3_digits_reg));
    assign int_next  = s3_q_reg + INT_W'(carry);
    assign frac_next = carry ? '0 : s3_f_reg;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // Advance payload with its stage
    always_ff @(posedge clk)
    begin
        if (s1_free && in_valid)
        begin
            s1_neg_reg    <= value_bits[31];
            s1_ovf_reg    <= s1_ovf_next;
            s1_rnd_reg    <= s1_rnd_next;
            s1_q_reg      <= s1_q_next;
            s1_rem_reg    <= s1_rem_next;
            s1_sh_reg     <= s1_sh_next;
            s1_digits_reg <= s1_digits_next;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_neg_reg    <= s1_neg_reg;
            s2_ovf_reg    <= s1_ovf_reg;
            s2_rnd_reg    <= s1_rnd_reg;
            s2_q_reg      <= s1_q_reg;
            s2_sh_reg     <= s1_sh_reg;
            s2_digits_reg <= s1_digits_reg;
            s2_prod_reg   <= s2_prod_next;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_neg_reg    <= s2_neg_reg;
            s3_ovf_reg    <= s2_ovf_reg;
            s3_q_reg      <= s2_q_reg;
            s3_digits_reg <= s2_digits_reg;
            s3_f_reg      <= f_wide[FRAC_W-1:0];
        end
        if (out_free && s3_valid_reg)
        begin
            neg_reg        <= s3_neg_reg;
            ovf_reg        <= s3_ovf_reg;
            int_reg        <= int_next;
            frac_reg       <= frac_next;
            out_digits_reg <= s3_digits_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign negative      = neg_reg;
    assign integer_part  = int_reg;
    assign fraction_part = frac_reg;
    assign overflow      = ovf_reg;

    // The fraction always stays below ten to its digit count.
    a_frac_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (frac_reg < pow10(out_digits_reg)))
        else $error("fraction not below ten to the digits");

    // A saturated result carries the largest integer and no fraction.
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ovf_reg) |-> (int_reg == INT_MAX && frac_reg == '0))
        else $error("overflow result not saturated");

    // Zero digits leave no fraction.
    a_zero_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_digits_reg == '0) |-> (frac_reg == '0))
        else $error("fraction present with zero digits");

    // Input back-pressure only arises from a full pipe behind a stalled output.
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && !out_ready && s1_valid_reg
                       && s2_valid_reg && s3_valid_reg))
        else $error("input stalled with room in the pipeline");

endmodule
